### sv/ssdct_pkg.sv
package ssdct_pkg;

  localparam int unsigned LINE_CAPACITY = 24;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned LINE_COUNT_W = 6;
  localparam int unsigned ACC_W = 17;
  localparam logic [15:0] MAX_DURATION_RESET = 16'd60000;
  localparam logic [15:0] OFF_TIME_RESET = 16'd1000;
  localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;

  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS = 8'd43;
  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  typedef enum logic [2:0] {
    STATUS_NONE      = 3'd0,
    STATUS_APPLIED   = 3'd1,
    STATUS_COMMA_ERR = 3'd2,
    STATUS_VALUE_ERR = 3'd3,
    STATUS_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_BAD    = 3'd4
  } parse_phase_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_NOTE  = 2'd1,
    CMD_APPLY = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic        output_on;
    logic [2:0]  status;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } result_t;

  typedef struct packed {
    cmd_kind_e   kind;
    status_e     status;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } cmd_t;

endpackage

### sv/ssdct_fifo.sv
module ssdct_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o = (count_q == CntW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### sv/ssdct_parser.sv
module ssdct_parser #(
  parameter int unsigned LineCapacity = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             valid_i,
  input  ssdct_pkg::item_t item_i,
  output ssdct_pkg::cmd_t  cmd_o
);

  import ssdct_pkg::*;

  logic [15:0]             max_duration_q;
  logic [LINE_COUNT_W-1:0] line_count_q, line_count_d;
  parse_phase_e            phase_q, phase_d;
  logic [1:0]              comma_count_q, comma_count_d;
  logic [ACC_W-1:0]        acc1_q, acc1_d, acc2_q, acc2_d;
  logic                    neg1_q, neg1_d, neg2_q, neg2_d, ok1_q, ok1_d, nul_q, nul_d;

  logic [7:0]       c;
  logic             is_space, is_digit, is_sign, first_field, active;
  logic [ACC_W-1:0] acc_cur, acc_next;
  logic [20:0]      acc_mul;
  logic             fld1_ok, fld2_ok;
  status_e          finish_status;
  logic             too_long, is_eol;

  assign c = item_i.char_in;
  assign is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_sign = (c == CHAR_PLUS) || (c == CHAR_MINUS);
  assign first_field = (comma_count_q == 2'd0);
  assign active = !nul_q && (comma_count_q < 2'd2);
  assign is_eol = (c == CHAR_CR) || (c == CHAR_LF);
  assign too_long = ({1'b0, line_count_q} + 7'd1) >= 7'(LineCapacity);

  assign acc_cur = first_field ? acc1_q : acc2_q;
  assign acc_mul = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0} + 21'(c - CHAR_ZERO);
  assign acc_next = (acc_mul > 21'(ACC_SAT)) ? ACC_SAT : acc_mul[ACC_W-1:0];

  assign fld1_ok = ok1_q && !(neg1_q && (acc1_q != '0)) && (acc1_q <= ACC_W'(max_duration_q));
  assign fld2_ok = ((phase_q == PH_DIGITS) || (phase_q == PH_TRAIL))
                   && !(neg2_q && (acc2_q != '0)) && (acc2_q <= ACC_W'(max_duration_q));

  always_comb begin
    if (comma_count_q != 2'd1) begin
      finish_status = STATUS_COMMA_ERR;
    end else if (!fld1_ok || !fld2_ok || ((acc1_q == '0) && (acc2_q == '0))) begin
      finish_status = STATUS_VALUE_ERR;
    end else begin
      finish_status = STATUS_APPLIED;
    end
  end

  // Next state of the field parser for one byte that joins the line.
  always_comb begin
    phase_d = phase_q;
    if (active && (c != CHAR_NUL)) begin
      if (c == CHAR_COMMA) begin
        phase_d = PH_LEAD;
      end else if (is_space) begin
        if (phase_q == PH_SIGN) begin
          phase_d = PH_BAD;
        end else if (phase_q == PH_DIGITS) begin
          phase_d = PH_TRAIL;
        end
      end else if (is_sign) begin
        phase_d = (phase_q == PH_LEAD) ? PH_SIGN : PH_BAD;
      end else if (is_digit) begin
        if ((phase_q == PH_LEAD) || (phase_q == PH_SIGN) || (phase_q == PH_DIGITS)) begin
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_BAD;
        end
      end else begin
        phase_d = PH_BAD;
      end
    end
  end

  always_comb begin
    line_count_d = line_count_q;
    comma_count_d = comma_count_q;
    acc1_d = acc1_q;
    acc2_d = acc2_q;
    neg1_d = neg1_q;
    neg2_d = neg2_q;
    ok1_d = ok1_q;
    nul_d = nul_q;
    cmd_o.kind = CMD_NOTE;
    cmd_o.status = STATUS_NONE;
    cmd_o.on_ms = acc1_q[15:0];
    cmd_o.off_ms = acc2_q[15:0];
    if (item_i.mode) begin
      cmd_o.kind = CMD_TICK;
    end else if (is_eol || too_long) begin
      if (too_long && !is_eol) begin
        cmd_o.status = STATUS_TOO_LONG;
      end else if (line_count_q != '0) begin
        cmd_o.status = finish_status;
        if (finish_status == STATUS_APPLIED) begin
          cmd_o.kind = CMD_APPLY;
        end
      end
    end else begin
      line_count_d = line_count_q + LINE_COUNT_W'(1);
      if (active) begin
        if (c == CHAR_NUL) begin
          nul_d = 1'b1;
        end else if (c == CHAR_COMMA) begin
          if (first_field && ((phase_q == PH_DIGITS) || (phase_q == PH_TRAIL))) begin
            ok1_d = 1'b1;
          end
          comma_count_d = comma_count_q + 2'd1;
        end else if (is_sign) begin
          if ((phase_q == PH_LEAD) && (c == CHAR_MINUS)) begin
            if (first_field) begin
              neg1_d = 1'b1;
            end else begin
              neg2_d = 1'b1;
            end
          end
        end else if (is_digit && ((phase_q == PH_LEAD) || (phase_q == PH_SIGN)
                                  || (phase_q == PH_DIGITS))) begin
          if (first_field) begin
            acc1_d = acc_next;
          end else begin
            acc2_d = acc_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_duration_q <= MAX_DURATION_RESET;
    end else if (cfg_we_i) begin
      max_duration_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
      phase_q <= PH_LEAD;
      comma_count_q <= '0;
      acc1_q <= '0;
      acc2_q <= '0;
      neg1_q <= 1'b0;
      neg2_q <= 1'b0;
      ok1_q <= 1'b0;
      nul_q <= 1'b0;
    end else if (valid_i && !item_i.mode) begin
      if (is_eol || too_long) begin
        line_count_q <= '0;
        phase_q <= PH_LEAD;
        comma_count_q <= '0;
        acc1_q <= '0;
        acc2_q <= '0;
        neg1_q <= 1'b0;
        neg2_q <= 1'b0;
        ok1_q <= 1'b0;
        nul_q <= 1'b0;
      end else begin
        line_count_q <= line_count_d;
        phase_q <= phase_d;
        comma_count_q <= comma_count_d;
        acc1_q <= acc1_d;
        acc2_q <= acc2_d;
        neg1_q <= neg1_d;
        neg2_q <= neg2_d;
        ok1_q <= ok1_d;
        nul_q <= nul_d;
      end
    end
  end

endmodule

### sv/ssdct_timer.sv
module ssdct_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ssdct_pkg::cmd_t     cmd_i,
  output ssdct_pkg::result_t  result_o
);

  import ssdct_pkg::*;

  logic [15:0] on_q, on_d, off_q, off_d, elapsed_q, elapsed_d, elapsed_inc, active;
  logic        drive_q, drive_d;
  status_e     status;

  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign active = drive_q ? on_q : off_q;

  always_comb begin
    on_d = on_q;
    off_d = off_q;
    elapsed_d = elapsed_q;
    drive_d = drive_q;
    status = cmd_i.status;
    case (cmd_i.kind)
      CMD_TICK: begin
        status = STATUS_NONE;
        elapsed_d = elapsed_inc;
        if (on_q == '0) begin
          drive_d = 1'b0;
        end else if (off_q == '0) begin
          drive_d = 1'b1;
        end else if (elapsed_inc >= active) begin
          elapsed_d = '0;
          drive_d = !drive_q;
        end
      end
      CMD_APPLY: begin
        on_d = cmd_i.on_ms;
        off_d = cmd_i.off_ms;
        elapsed_d = '0;
        drive_d = (cmd_i.on_ms != '0);
      end
      default: begin
      end
    endcase
    result_o.output_on = drive_d;
    result_o.status = status;
    result_o.on_ms = on_d;
    result_o.off_ms = off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q <= '0;
      off_q <= OFF_TIME_RESET;
      elapsed_q <= '0;
      drive_q <= 1'b0;
    end else if (valid_i) begin
      on_q <= on_d;
      off_q <= off_d;
      elapsed_q <= elapsed_d;
      drive_q <= drive_d;
    end
  end

endmodule

### sv/serial_set_duty_cycle_timer.sv
// Duty-cycle timer for a heater output, set by "ON,OFF" text lines over a serial
// link and paced by one-millisecond ticks. Each accepted transaction (a byte or
// a tick) yields exactly one result, in order, carrying the drive level, the
// line status and the current durations. One transaction is accepted per clock
// cycle while the command queue is not full: a parser front end combinationally
// classifies each byte or tick into a command, a command queue of QueueDepth
// entries holds it, and the timer back end executes one command per cycle, while
// the result queue is not full, into a result queue of the same depth. Results
// leave through the result queue, and full rises only when the command queue is
// full because results are not popped.
module serial_set_duty_cycle_timer #(
  parameter int unsigned LineCapacity = ssdct_pkg::LINE_CAPACITY,
  parameter int unsigned QueueDepth = ssdct_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  ssdct_pkg::item_t   item_i,
  input  logic               pop,
  output logic               empty,
  output ssdct_pkg::result_t result_o
);

  import ssdct_pkg::*;

  cmd_t    cmd_in, cmd_out;
  result_t timer_result;
  logic    cmd_empty, cmd_full, res_full, cmd_pop, accept;

  assign full = cmd_full;
  assign accept = push && !cmd_full;
  assign cmd_pop = !cmd_empty && !res_full;

  ssdct_parser #(
    .LineCapacity(LineCapacity)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_i    (accept),
    .item_i     (item_i),
    .cmd_o      (cmd_in)
  );

  ssdct_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QueueDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i(cmd_in),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_out),
    .empty_o(cmd_empty),
    .full_o (cmd_full)
  );

  ssdct_timer u_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_pop),
    .cmd_i   (cmd_out),
    .result_o(timer_result)
  );

  ssdct_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QueueDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_pop),
    .wdata_i(timer_result),
    .pop_i  (pop),
    .rdata_o(result_o),
    .empty_o(empty),
    .full_o (res_full)
  );

endmodule

### bench/duty_timer_checker.sv
module duty_timer_checker
  import ssdct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push_i,
  input  logic        full_i,
  input  item_t       item_i,
  input  logic        pop_i,
  input  logic        empty_i,
  input  result_t     result_i,
  output int          mismatches_o,
  output int          outstanding_o,
  output int          applied_o
);

  logic [15:0] limit_ms;
  logic [15:0] on_dur;
  logic [15:0] off_dur;
  logic [15:0] elapsed_ms;
  logic        drive;
  logic [5:0]  line_len;
  parse_phase_e field_state;
  logic [1:0]  commas;
  logic [ACC_W-1:0] first_acc;
  logic [ACC_W-1:0] second_acc;
  logic        neg_first;
  logic        neg_second;
  logic        first_ok;
  logic        nul_seen;

  result_t timer_reports[$];

  function automatic void wipe_line();
    line_len = '0;
    field_state = PH_LEAD;
    commas = '0;
    first_acc = '0;
    second_acc = '0;
    neg_first = 1'b0;
    neg_second = 1'b0;
    first_ok = 1'b0;
    nul_seen = 1'b0;
  endfunction

  function automatic bit duration_ok(bit well_formed, bit negative, logic [ACC_W-1:0] acc);
    if (!well_formed) return 1'b0;
    if (negative && acc != 0) return 1'b0;
    return acc <= limit_ms;
  endfunction

  task automatic advance_timer(input item_t it, output result_t r);
    status_e st;
    logic [7:0] c;
    logic [31:0] grown;
    st = STATUS_NONE;
    c = it.char_in;
    if (it.mode) begin
      if (elapsed_ms != 16'hFFFF) elapsed_ms = elapsed_ms + 1'b1;
      if (on_dur == 0) begin
        drive = 1'b0;
      end else if (off_dur == 0) begin
        drive = 1'b1;
      end else if (elapsed_ms >= (drive ? on_dur : off_dur)) begin
        elapsed_ms = '0;
        drive = ~drive;
      end
    end else if (c == CHAR_CR || c == CHAR_LF) begin
      if (line_len != 0) begin
        if (commas != 2'd1) begin
          st = STATUS_COMMA_ERR;
        end else if (!duration_ok(first_ok, neg_first, first_acc) ||
                     !duration_ok(field_state == PH_DIGITS || field_state == PH_TRAIL,
                                  neg_second, second_acc) ||
                     (first_acc == 0 && second_acc == 0)) begin
          st = STATUS_VALUE_ERR;
        end else begin
          on_dur = first_acc[15:0];
          off_dur = second_acc[15:0];
          elapsed_ms = '0;
          drive = (first_acc != 0);
          st = STATUS_APPLIED;
        end
        wipe_line();
      end
    end else if (int'(line_len) + 1 >= LINE_CAPACITY) begin
      wipe_line();
      st = STATUS_TOO_LONG;
    end else begin
      line_len = line_len + 1'b1;
      if (!nul_seen && commas < 2'd2) begin
        if (c == CHAR_NUL) begin
          nul_seen = 1'b1;
        end else if (c == CHAR_COMMA) begin
          if (commas == 0 && (field_state == PH_DIGITS || field_state == PH_TRAIL)) begin
            first_ok = 1'b1;
          end
          commas = commas + 1'b1;
          field_state = PH_LEAD;
        end else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
          if (field_state == PH_SIGN) field_state = PH_BAD;
          else if (field_state == PH_DIGITS) field_state = PH_TRAIL;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          if (field_state == PH_LEAD) begin
            field_state = PH_SIGN;
            if (c == CHAR_MINUS) begin
              if (commas == 0) neg_first = 1'b1;
              else neg_second = 1'b1;
            end
          end else begin
            field_state = PH_BAD;
          end
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          if (field_state == PH_LEAD || field_state == PH_SIGN || field_state == PH_DIGITS) begin
            grown = 32'(commas == 0 ? first_acc : second_acc) * 32'd10 + 32'(c - CHAR_ZERO);
            if (grown > 32'(ACC_SAT)) grown = 32'(ACC_SAT);
            if (commas == 0) first_acc = grown[ACC_W-1:0];
            else second_acc = grown[ACC_W-1:0];
            field_state = PH_DIGITS;
          end else begin
            field_state = PH_BAD;
          end
        end else begin
          field_state = PH_BAD;
        end
      end
    end
    r.output_on = drive;
    r.status = st;
    r.on_ms = on_dur;
    r.off_ms = off_dur;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      limit_ms = MAX_DURATION_RESET;
      on_dur = '0;
      off_dur = OFF_TIME_RESET;
      elapsed_ms = '0;
      drive = 1'b0;
      wipe_line();
      timer_reports.delete();
      mismatches_o = 0;
      outstanding_o = 0;
      applied_o = 0;
    end else begin
      if (cfg_we_i) limit_ms = cfg_wdata_i;
      if (pop_i && !empty_i) begin
        got = result_i;
        if (timer_reports.size() == 0) begin
          $error("Result transaction arrived with nothing pending.");
          mismatches_o++;
        end else begin
          want = timer_reports.pop_front();
          if (got.output_on !== want.output_on) begin
            $error("output_on expected %0d, got %0d", want.output_on, got.output_on);
            mismatches_o++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d, got %0d", want.status, got.status);
            mismatches_o++;
          end
          if (got.on_ms !== want.on_ms) begin
            $error("on_ms expected %0d, got %0d", want.on_ms, got.on_ms);
            mismatches_o++;
          end
          if (got.off_ms !== want.off_ms) begin
            $error("off_ms expected %0d, got %0d", want.off_ms, got.off_ms);
            mismatches_o++;
          end
        end
      end
      if (push_i && !full_i) begin
        advance_timer(item_i, want);
        if (want.status == STATUS_APPLIED) applied_o++;
        timer_reports.push_back(want);
      end
      outstanding_o = timer_reports.size();
    end
  end

endmodule

### bench/serial_set_duty_cycle_timer_test.sv
module serial_set_duty_cycle_timer_test;
  import ssdct_pkg::*;

  localparam logic [7:0] CHAR_VT = 8'd11;
  localparam logic [7:0] CHAR_FF = 8'd12;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  item_t       stim_item = '0;
  logic        pop = 1'b0;
  logic        empty;
  result_t     reading;

  int mismatches;
  int outstanding;
  int applied;

  bit send_idles = 1'b1;
  bit drain_idles = 1'b1;
  int bytes_sent;
  int ticks_sent;
  int limits_written;
  logic [15:0] limit_now = MAX_DURATION_RESET;
  logic [7:0] draft[$];

  serial_set_duty_cycle_timer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .push       (push),
    .full       (full),
    .item_i     (stim_item),
    .pop        (pop),
    .empty      (empty),
    .result_o   (reading)
  );

  duty_timer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .push_i       (push),
    .full_i       (full),
    .item_i       (stim_item),
    .pop_i        (pop),
    .empty_i      (empty),
    .result_i     (reading),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .applied_o    (applied)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap(bit idles);
    int r;
    if (!idles) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_VT;
      default: return CHAR_FF;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CHAR_ZERO + 8'($urandom_range(0, 9));
    if (r < 45) return CHAR_COMMA;
    if (r < 55) return pick_blank();
    if (r < 65) return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
    if (r < 70) return CHAR_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_field(logic [15:0] limit);
    int r;
    int v;
    int i;
    string digits;
    r = $urandom_range(0, 99);
    if (r < 40) v = $urandom_range(0, 12);
    else if (r < 55) v = 0;
    else if (r < 70) v = int'(limit) - 1 + int'($urandom_range(0, 2));
    else if (r < 85) v = $urandom_range(13, 400);
    else if (r < 95) v = $urandom_range(0, 65535);
    else v = $urandom_range(65536, 9999999);
    if (v < 0) v = 0;
    repeat ($urandom_range(0, 1) * $urandom_range(0, 2)) draft.push_back(pick_blank());
    r = $urandom_range(0, 19);
    if (r < 2) draft.push_back(CHAR_PLUS);
    else if (r < 4) draft.push_back(CHAR_MINUS);
    else if (r == 4) draft.push_back(CHAR_ZERO);
    digits = $sformatf("%0d", v);
    for (i = 0; i < digits.len(); i++) draft.push_back(digits[i]);
    if ($urandom_range(0, 7) == 0) draft.push_back(pick_blank());
  endfunction

  function automatic void add_setting();
    add_field(limit_now);
    draft.push_back(CHAR_COMMA);
    add_field(limit_now);
  endfunction

  function automatic void add_end();
    bit cr_first;
    cr_first = $urandom_range(0, 1);
    draft.push_back(cr_first ? CHAR_CR : CHAR_LF);
    if ($urandom_range(0, 9) == 0) draft.push_back(cr_first ? CHAR_LF : CHAR_CR);
  endfunction

  task automatic send_item(input logic mode, input logic [7:0] c);
    int gap;
    gap = pick_gap(send_idles);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    stim_item <= '{mode: mode, char_in: c};
    while (full) @(negedge clk_i);
    @(negedge clk_i);
    if (mode) ticks_sent++;
    else bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_draft();
    foreach (draft[i]) send_item(1'b0, draft[i]);
    draft.delete();
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [15:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    limit_now = v;
    limits_written++;
  endtask

  task automatic random_traffic(input int n);
    int goal;
    int r;
    int i;
    int target;
    goal = bytes_sent + ticks_sent + n;
    while (bytes_sent + ticks_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add_setting();
        add_end();
        send_draft();
        send_ticks($urandom_range(0, 25));
      end else if (r < 62) begin
        if ($urandom_range(0, 1)) begin
          add_setting();
          draft[$urandom_range(0, draft.size() - 1)] = noise_byte();
        end else begin
          repeat ($urandom_range(0, 12)) draft.push_back(noise_byte());
        end
        add_end();
        send_draft();
      end else if (r < 70) begin
        add_setting();
        target = $urandom_range(20, 27);
        for (i = draft.size(); i < target; i++) draft.push_front(pick_blank());
        add_end();
        send_draft();
        send_ticks($urandom_range(0, 10));
      end else if (r < 80) begin
        send_ticks($urandom_range(1, 40));
      end else begin
        repeat ($urandom_range(1, 4)) draft.push_back(8'($urandom_range(0, 255)));
        send_draft();
      end
    end
  endtask

  initial begin
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int stall;
      stall = pick_gap(drain_idles);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  end

  initial begin
    logic [15:0] limits[7];
    int p;
    limits = '{16'hFFFF, 16'd0, 16'd1, 16'd12, 16'd300, 16'd60000,
               16'($urandom_range(0, 65535))};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(1'b1, 8'hFF);
    send_text("7,2\n");
    send_ticks(3);
    send_item(1'b0, CHAR_CR);
    send_text("9\n");
    send_text("-1,0\r");
    send_item(1'b0, CHAR_NUL);
    send_text(",\n");
    send_text("70000,1\n");

    for (p = 0; p < 7; p++) begin
      set_limit(limits[p]);
      send_idles = (p % 3 != 1);
      drain_idles = (p % 3 != 2);
      random_traffic(250);
    end

    // Longest durations the 16-bit fields allow, with both sides running flat out.
    set_limit(16'hFFFF);
    send_idles = 1'b0;
    drain_idles = 1'b0;
    send_text("65535,65535\r");
    send_ticks(20);

    settle();
    repeat (10) @(negedge clk_i);
    if (outstanding != 0) $error("%0d results never arrived", outstanding);
    $display("Sent %0d serial bytes and %0d ticks under %0d written duration limits.",
             bytes_sent, ticks_sent, limits_written);
    $display("%0d lines were applied, the last one setting 65535 ms on and off.", applied);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
